// ===== design/sst_pkg.sv =====
// Shared types and constants for the sparse set table.
package sst_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 12;
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 9;

    localparam logic [OP_W-1:0] OP_PUT     = 3'd0;
    localparam logic [OP_W-1:0] OP_RESERVE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET     = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic check;
        logic fetch;
        logic rem_fin;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic remove_hit;
    } sts_t;

endpackage

// ===== design/sst_ctrl.sv =====
// Controller state machine: sequences clear pass, lookup, access, remove and output load.
module sst_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output sst_pkg::cmd_t cmd,
    input  sst_pkg::sts_t sts
);
    import sst_pkg::*;

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_CLEAR  = 3'd0;
    localparam logic [STATE_W-1:0] S_IDLE   = 3'd1;
    localparam logic [STATE_W-1:0] S_CHECK  = 3'd2;
    localparam logic [STATE_W-1:0] S_FETCH  = 3'd3;
    localparam logic [STATE_W-1:0] S_REMOVE = 3'd4;
    localparam logic [STATE_W-1:0] S_DONE   = 3'd5;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = sts.remove_hit ? S_REMOVE : S_DONE;
            end
            S_REMOVE:
            begin
                cmd.rem_fin = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/sst_datapath.sv =====
// Datapath: key map and dense stores, entry count, result and output registers.
module sst_datapath #(
    parameter int KEY_COUNT   = 4096,
    parameter int DENSE_DEPTH = 256,
    parameter int DATA_BITS   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sst_pkg::cmd_t                   cmd,
    output sst_pkg::sts_t                   sts,
    input  logic [sst_pkg::OP_W-1:0]        op,
    input  logic [sst_pkg::KEY_W-1:0]       key,
    input  logic [sst_pkg::VALUE_W-1:0]     value,
    input  logic [sst_pkg::SLOT_W-1:0]      slot,
    output logic [sst_pkg::STATUS_W-1:0]    status,
    output logic [sst_pkg::VALUE_W-1:0]     data,
    output logic [sst_pkg::KEY_W-1:0]       owner_key,
    output logic [sst_pkg::SLOT_W-1:0]      position,
    output logic [sst_pkg::OCC_W-1:0]       occupancy
);
    import sst_pkg::*;

    localparam int KEY_AW  = $clog2(KEY_COUNT);
    localparam int SLOT_AW = $clog2(DENSE_DEPTH);
    localparam int CNT_W   = $clog2(DENSE_DEPTH + 1);
    localparam int MAP_W   = CNT_W;
    localparam int KEY_XW  = KEY_W + KEY_AW;
    localparam int SLOT_XW = SLOT_W + CNT_W;

    logic [MAP_W-1:0]     key_map_mem [KEY_COUNT];
    logic [DATA_BITS-1:0] data_mem    [DENSE_DEPTH];
    logic [KEY_W-1:0]     owner_mem   [DENSE_DEPTH];

    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [DATA_BITS-1:0] value_reg;
    logic [SLOT_W-1:0]    slot_reg;

    logic [KEY_AW-1:0]    clr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [MAP_W-1:0]     map_q_reg;
    logic [DATA_BITS-1:0] data_a_reg;
    logic [DATA_BITS-1:0] data_b_reg;
    logic [KEY_W-1:0]     owner_q_reg;
    logic                 found_reg;
    logic                 slot_ok_reg;
    logic [SLOT_AW-1:0]   pos_reg;
    logic [SLOT_AW-1:0]   slot_addr_reg;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [DATA_BITS-1:0] res_data_reg,   res_data_next;
    logic [KEY_W-1:0]     res_owner_reg,  res_owner_next;
    logic [SLOT_AW-1:0]   res_pos_reg,    res_pos_next;

    logic [STATUS_W-1:0]  status_reg;
    logic [VALUE_W-1:0]   data_reg;
    logic [KEY_W-1:0]     owner_reg;
    logic [SLOT_W-1:0]    position_reg;
    logic [OCC_W-1:0]     occupancy_reg;

    logic [KEY_XW-1:0]    in_key_ext, key_ext, tail_key_ext;
    logic [KEY_AW-1:0]    in_addr, key_addr, tail_key_addr;
    logic                 key_ok, tail_key_ok;
    logic [DATA_BITS+VALUE_W-1:0] value_ext;
    logic [DATA_BITS+VALUE_W-1:0] res_data_ext;
    logic [SLOT_XW-1:0]   slot_ext, cnt_ext;
    logic [SLOT_AW+SLOT_W-1:0] res_pos_ext;
    logic [CNT_W+OCC_W-1:0]    count_ext;
    logic [SLOT_AW-1:0]   slot_addr, pos_c, tail_c, rd_a, rd_o;
    logic [MAP_W-1:0]     pos_full;
    logic [CNT_W-1:0]     tail_full;
    logic                 found_c, slot_ok_c, full_c;

    logic                 map_we, fmap_we;
    logic [KEY_AW-1:0]    map_wa, fmap_wa;
    logic [MAP_W-1:0]     map_wd, fmap_wd;
    logic                 data_we, owner_we, count_inc;
    logic [SLOT_AW-1:0]   data_wa, owner_wa;
    logic [DATA_BITS-1:0] data_wd;
    logic [KEY_W-1:0]     owner_wd;

    assign in_key_ext   = {{KEY_AW{1'b0}}, key};
    assign in_addr      = in_key_ext[KEY_AW-1:0];
    assign key_ext      = {{KEY_AW{1'b0}}, key_reg};
    assign key_addr     = key_ext[KEY_AW-1:0];
    assign key_ok       = key_ext < KEY_XW'(KEY_COUNT);
    assign tail_key_ext = {{KEY_AW{1'b0}}, owner_q_reg};
    assign tail_key_addr = tail_key_ext[KEY_AW-1:0];
    assign tail_key_ok  = tail_key_ext < KEY_XW'(KEY_COUNT);
    assign value_ext    = {{DATA_BITS{1'b0}}, value};

    // lookup decode
    assign pos_full  = map_q_reg - MAP_W'(1);
    assign pos_c     = pos_full[SLOT_AW-1:0];
    assign found_c   = key_ok && (map_q_reg != '0) && (map_q_reg <= count_reg);
    assign tail_full = count_reg - CNT_W'(1);
    assign tail_c    = tail_full[SLOT_AW-1:0];
    assign slot_ext  = {{CNT_W{1'b0}}, slot_reg};
    assign cnt_ext   = {{SLOT_W{1'b0}}, count_reg};
    assign slot_ok_c = slot_ext < cnt_ext;
    assign slot_addr = slot_ext[SLOT_AW-1:0];
    assign rd_a      = (op_reg == OP_READ) ? slot_addr : pos_c;
    assign rd_o      = (op_reg == OP_READ) ? slot_addr : tail_c;
    assign full_c    = (count_reg == CNT_W'(DENSE_DEPTH));

    // access step: result and store updates
    always_comb
    begin
        res_status_next = ST_OK;
        res_data_next   = '0;
        res_owner_next  = '0;
        res_pos_next    = '0;
        data_we         = 1'b0;
        data_wa         = pos_reg;
        data_wd         = value_reg;
        owner_we        = 1'b0;
        owner_wa        = pos_reg;
        owner_wd        = owner_q_reg;
        fmap_we         = 1'b0;
        fmap_wa         = key_addr;
        fmap_wd         = MAP_W'(pos_reg) + MAP_W'(1);
        count_inc       = 1'b0;
        case (op_reg) inside
            OP_PUT, OP_RESERVE:
            begin
                if (!key_ok)
                begin
                    res_status_next = ST_ABSENT;
                end
                else if (found_reg)
                begin
                    data_we       = (op_reg == OP_PUT);
                    res_data_next = (op_reg == OP_PUT) ? value_reg : data_a_reg;
                    res_pos_next  = pos_reg;
                end
                else if (full_c)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    data_we       = (op_reg == OP_PUT);
                    data_wa       = count_reg[SLOT_AW-1:0];
                    owner_we      = 1'b1;
                    owner_wa      = count_reg[SLOT_AW-1:0];
                    owner_wd      = key_reg;
                    fmap_we       = 1'b1;
                    fmap_wd       = count_reg + CNT_W'(1);
                    count_inc     = 1'b1;
                    res_data_next = (op_reg == OP_PUT) ? value_reg : '0;
                    res_pos_next  = count_reg[SLOT_AW-1:0];
                end
            end
            OP_GET:
            begin
                if (found_reg)
                begin
                    res_data_next = data_a_reg;
                    res_pos_next  = pos_reg;
                end
                else
                begin
                    res_status_next = ST_ABSENT;
                end
            end
            OP_REMOVE:
            begin
                if (found_reg)
                begin
                    res_data_next = data_a_reg;
                    res_pos_next  = pos_reg;
                    data_we       = 1'b1;
                    data_wd       = data_b_reg;
                    owner_we      = 1'b1;
                    fmap_we       = tail_key_ok;
                    fmap_wa       = tail_key_addr;
                end
                else
                begin
                    res_status_next = ST_ABSENT;
                end
            end
            OP_READ:
            begin
                if (slot_ok_reg)
                begin
                    res_data_next  = data_a_reg;
                    res_owner_next = owner_q_reg;
                    res_pos_next   = slot_addr_reg;
                end
                else
                begin
                    res_status_next = ST_RANGE;
                end
            end
            default:
            begin
                res_status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        map_we = 1'b0;
        map_wa = fmap_wa;
        map_wd = fmap_wd;
        if (cmd.clear_wr)
        begin
            map_we = 1'b1;
            map_wa = clr_reg;
            map_wd = '0;
        end
        else if (cmd.rem_fin)
        begin
            map_we = 1'b1;
            map_wa = key_addr;
            map_wd = '0;
        end
        else if (cmd.fetch)
        begin
            map_we = fmap_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            key_map_mem[map_wa] <= map_wd;
        end
        if (cmd.accept)
        begin
            map_q_reg <= key_map_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch && data_we)
        begin
            data_mem[data_wa] <= data_wd;
        end
        if (cmd.check)
        begin
            data_a_reg <= data_mem[rd_a];
            data_b_reg <= data_mem[tail_c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fetch && owner_we)
        begin
            owner_mem[owner_wa] <= owner_wd;
        end
        if (cmd.check)
        begin
            owner_q_reg <= owner_mem[rd_o];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value_ext[DATA_BITS-1:0];
            slot_reg  <= slot;
        end
        if (cmd.check)
        begin
            found_reg     <= found_c;
            slot_ok_reg   <= slot_ok_c;
            pos_reg       <= pos_c;
            slot_addr_reg <= slot_addr;
        end
        if (cmd.fetch)
        begin
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
            res_owner_reg  <= res_owner_next;
            res_pos_reg    <= res_pos_next;
        end
        if (cmd.load_out)
        begin
            status_reg    <= res_status_reg;
            data_reg      <= res_data_ext[VALUE_W-1:0];
            owner_reg     <= res_owner_reg;
            position_reg  <= res_pos_ext[SLOT_W-1:0];
            occupancy_reg <= count_ext[OCC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_reg <= clr_reg + KEY_AW'(1);
            end
            if (cmd.fetch && count_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.rem_fin)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign res_data_ext = {{VALUE_W{1'b0}}, res_data_reg};
    assign res_pos_ext  = {{SLOT_W{1'b0}}, res_pos_reg};
    assign count_ext    = {{OCC_W{1'b0}}, count_reg};

    assign sts.clear_last = (clr_reg == KEY_AW'(KEY_COUNT - 1));
    assign sts.remove_hit = (op_reg == OP_REMOVE) && found_reg;

    assign status    = status_reg;
    assign data      = data_reg;
    assign owner_key = owner_reg;
    assign position  = position_reg;
    assign occupancy = occupancy_reg;

endmodule

// ===== design/sparse_set_table.sv =====
// Top level of the sparse set table: controller, datapath and checks.
// Sparse set table: maps keys to packed dense slots with put, reserve, get, remove
// (the last entry moves into the freed slot) and read by slot. After reset the key
// map is cleared one entry per cycle, all KEY_COUNT entries (4096 by default), with
// in_stall high throughout. Afterwards one item is processed at a time and the next
// item is accepted only once the last one has been loaded into the output register.
// Each item runs through the controller's steps: a key map read, a dense store read,
// the access and store update, and the output load; remove adds a second key map write
// on the single map write port before the output load. A finished result waits in the
// output register while the next item is accepted; that item then waits for the output
// register before it can finish.
module sparse_set_table #(
    parameter int KEY_COUNT   = 4096,
    parameter int DENSE_DEPTH = 256,
    parameter int DATA_BITS   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sst_pkg::OP_W-1:0]        op,
    input  logic [sst_pkg::KEY_W-1:0]       key,
    input  logic [sst_pkg::VALUE_W-1:0]     value,
    input  logic [sst_pkg::SLOT_W-1:0]      slot,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [sst_pkg::STATUS_W-1:0]    status,
    output logic [sst_pkg::VALUE_W-1:0]     data,
    output logic [sst_pkg::KEY_W-1:0]       owner_key,
    output logic [sst_pkg::SLOT_W-1:0]      position,
    output logic [sst_pkg::OCC_W-1:0]       occupancy
);
    import sst_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    sst_datapath #(
        .KEY_COUNT   (KEY_COUNT),
        .DENSE_DEPTH (DENSE_DEPTH),
        .DATA_BITS   (DATA_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .key       (key),
        .value     (value),
        .slot      (slot),
        .status    (status),
        .data      (data),
        .owner_key (owner_key),
        .position  (position),
        .occupancy (occupancy)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while previous item still in progress");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("output loaded over a stalled item");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !(cmd.check || cmd.fetch || cmd.rem_fin || cmd.load_out
                        || cmd.clear_wr))
        else $error("datapath command issued while idle");

    a_rise_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("out_valid raised without an output load");

endmodule

// ===== sim/sst_result_checker.sv =====
// Checker for the sparse set table: tracks the table, predicts each result and compares it.
module sst_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [sst_pkg::OP_W-1:0]      op,
    input  logic [sst_pkg::KEY_W-1:0]     key,
    input  logic [sst_pkg::VALUE_W-1:0]   value,
    input  logic [sst_pkg::SLOT_W-1:0]    slot,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [sst_pkg::STATUS_W-1:0]  status,
    input  logic [sst_pkg::VALUE_W-1:0]   data,
    input  logic [sst_pkg::KEY_W-1:0]     owner_key,
    input  logic [sst_pkg::SLOT_W-1:0]    position,
    input  logic [sst_pkg::OCC_W-1:0]     occupancy,
    input  logic                          closing,
    output int                            fail_count
);
    import sst_pkg::*;

    localparam int KEY_COUNT   = 4096;
    localparam int DENSE_DEPTH = 256;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  data;
        logic [KEY_W-1:0]    owner_key;
        logic [SLOT_W-1:0]   position;
        logic [OCC_W-1:0]    occupancy;
    } answer_t;

    logic [OCC_W-1:0]   key_slot [KEY_COUNT];     // slot + 1, zero when absent
    logic [VALUE_W-1:0] dense_data [DENSE_DEPTH];
    logic [KEY_W-1:0]   dense_key [DENSE_DEPTH];
    logic [OCC_W-1:0]   used;
    answer_t            answers_due [$];
    int                 errors = 0;
    bit                 closed = 1'b0;

    assign fail_count = errors;

    function automatic answer_t apply_request(logic [OP_W-1:0] code, logic [KEY_W-1:0] k,
                                              logic [VALUE_W-1:0] v, logic [SLOT_W-1:0] s);
        answer_t          a;
        int               at;
        int               tail;
        logic [KEY_W-1:0] tail_key;
        a = '0;
        at = int'(key_slot[k]) - 1;
        if (at >= int'(used))
            at = -1;
        tail = int'(used) - 1;
        case (code)
            OP_PUT, OP_RESERVE:
                if (at >= 0)
                begin
                    if (code == OP_PUT)
                        dense_data[at] = v;
                    dense_key[at] = k;
                    a.data = dense_data[at];
                    a.position = SLOT_W'(at);
                end
                else if (used >= DENSE_DEPTH)
                    a.status = ST_FULL;
                else
                begin
                    key_slot[k] = used + 1'b1;
                    dense_key[used] = k;
                    if (code == OP_PUT)
                    begin
                        dense_data[used] = v;
                        a.data = v;
                    end
                    a.position = SLOT_W'(used);
                    used = used + 1'b1;
                end
            OP_GET:
                if (at >= 0)
                begin
                    a.data = dense_data[at];
                    a.position = SLOT_W'(at);
                end
                else
                    a.status = ST_ABSENT;
            OP_REMOVE:
                if (at >= 0)
                begin
                    // tail entry fills the hole; its key is patched before ours is cleared
                    tail_key = dense_key[tail];
                    a.data = dense_data[at];
                    a.position = SLOT_W'(at);
                    dense_data[at] = dense_data[tail];
                    dense_key[at] = tail_key;
                    key_slot[tail_key] = OCC_W'(at + 1);
                    key_slot[k] = '0;
                    used = used - 1'b1;
                end
                else
                    a.status = ST_ABSENT;
            OP_READ:
                if (s < used)
                begin
                    a.data = dense_data[s];
                    a.owner_key = dense_key[s];
                    a.position = s;
                end
                else
                    a.status = ST_RANGE;
            default: ;
        endcase
        a.occupancy = used;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            foreach (key_slot[i])
                key_slot[i] = '0;
            used = '0;
            answers_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result arrived with no item outstanding");
                    errors++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, status);
                        errors++;
                    end
                    if (data !== want.data)
                    begin
                        $error("data expected %h got %h", want.data, data);
                        errors++;
                    end
                    if (owner_key !== want.owner_key)
                    begin
                        $error("owner_key expected %0d got %0d", want.owner_key, owner_key);
                        errors++;
                    end
                    if (position !== want.position)
                    begin
                        $error("position expected %0d got %0d", want.position, position);
                        errors++;
                    end
                    if (occupancy !== want.occupancy)
                    begin
                        $error("occupancy expected %0d got %0d", want.occupancy, occupancy);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                answers_due.push_back(apply_request(op, key, value, slot));
            if (closing && !closed)
            begin
                closed = 1'b1;
                if (answers_due.size() != 0)
                begin
                    $error("%0d results never arrived", answers_due.size());
                    errors += answers_due.size();
                end
            end
        end
    end

endmodule

// ===== sim/tb_sparse_set_table.sv =====
// Testbench top for the sparse set table: clock, reset, stimulus, receiver stalls and verdict.
module tb_sparse_set_table;
    import sst_pkg::*;

    localparam int ITEM_TARGET = 950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int KEYS        = 4096;
    localparam int DEPTH       = 256;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_stall = 1'b0;
    logic [OP_W-1:0]     op        = OP_PUT;
    logic [KEY_W-1:0]    key       = '0;
    logic [VALUE_W-1:0]  value     = '0;
    logic [SLOT_W-1:0]   slot      = '0;
    logic                in_stall;
    logic                out_valid;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [KEY_W-1:0]    owner_key;
    logic [SLOT_W-1:0]   position;
    logic [OCC_W-1:0]    occupancy;
    logic                checks_closed = 1'b0;
    int                  fail_count;

    int sent = 0;
    int seen = 0;
    int cycles = 0;
    int stall_left = 0;
    bit calm = 1'b0;

    // layout of the table, kept so that no slot is read before its data is written
    int               lay_map [KEYS];
    logic [KEY_W-1:0] lay_owner [DEPTH];
    bit               lay_filled [DEPTH];
    int               lay_count = 0;

    sparse_set_table u_top (
        .clk, .rst_n, .in_valid, .in_stall, .op, .key, .value, .slot,
        .out_valid, .out_stall, .status, .data, .owner_key, .position, .occupancy
    );

    sst_result_checker u_check (
        .clk, .rst_n, .in_valid, .in_stall, .op, .key, .value, .slot,
        .out_valid, .out_stall, .status, .data, .owner_key, .position, .occupancy,
        .closing(checks_closed), .fail_count
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            seen <= seen + 1;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    function automatic logic [KEY_W-1:0] pick_key(int live_pct);
        if (lay_count > 0 && $urandom_range(0, 99) < live_pct)
            return lay_owner[$urandom_range(0, lay_count - 1)];
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 1) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
        return KEY_W'($urandom);
    endfunction

    task automatic issue(logic [OP_W-1:0] op_i, logic [KEY_W-1:0] key_i,
                         logic [VALUE_W-1:0] value_i, logic [SLOT_W-1:0] slot_i, int gap);
        int at;
        int tail;
        at = lay_map[key_i] - 1;
        tail = lay_count - 1;
        // an access to unwritten data becomes a put that writes it
        if ((op_i == OP_GET || op_i == OP_RESERVE || op_i == OP_REMOVE) && at >= 0
            && !lay_filled[at])
            op_i = OP_PUT;
        else if (op_i == OP_REMOVE && at >= 0 && !lay_filled[tail])
        begin
            op_i = OP_PUT;
            key_i = lay_owner[tail];
        end
        else if (op_i == OP_READ && slot_i < lay_count && !lay_filled[slot_i])
        begin
            op_i = OP_PUT;
            key_i = lay_owner[slot_i];
        end
        at = lay_map[key_i] - 1;
        case (op_i)
            OP_PUT, OP_RESERVE:
                if (at >= 0)
                begin
                    if (op_i == OP_PUT)
                        lay_filled[at] = 1'b1;
                end
                else if (lay_count < DEPTH)
                begin
                    lay_map[key_i] = lay_count + 1;
                    lay_owner[lay_count] = key_i;
                    lay_filled[lay_count] = (op_i == OP_PUT);
                    lay_count++;
                end
            OP_REMOVE:
                if (at >= 0)
                begin
                    lay_filled[at] = lay_filled[tail];
                    lay_owner[at] = lay_owner[tail];
                    lay_map[lay_owner[tail]] = at + 1;
                    lay_map[key_i] = 0;
                    lay_count--;
                end
            default: ;
        endcase

        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= op_i;
        key <= key_i;
        value <= value_i;
        slot <= slot_i;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    initial
    begin : stimulus
        int               n;
        int               r;
        int               full_hits;
        bit               filling;
        logic [OP_W-1:0]  pick;
        logic [SLOT_W-1:0] pos_pick;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        issue(OP_GET, '0, '0, '0, 0);
        issue(OP_REMOVE, '1, '1, '0, 0);
        issue(OP_READ, '0, '0, '0, 0);
        issue(OP_READ, '0, '0, '1, 0);
        issue(OP_PUT, '0, '0, '0, 0);
        issue(OP_PUT, '1, '1, '1, 0);
        issue(OP_PUT, '0, 32'h1234_5678, '0, 1);
        issue(OP_RESERVE, '1, '0, '0, 0);
        issue(OP_RESERVE, 12'd100, '0, '0, 0);
        issue(OP_PUT, 12'd100, 32'hA5A5_5A5A, '0, 2);
        issue(OP_GET, '1, '0, '0, 0);
        issue(OP_GET, '0, '0, '0, 0);
        for (n = 0; n < 4; n++)
            issue(OP_READ, '0, '0, SLOT_W'(n), 0);
        issue(OP_REMOVE, '0, '0, '0, 0);       // tail moves into slot 0
        issue(OP_REMOVE, '1, '0, '0, 0);       // entry is the tail
        for (n = OP_READ + 1; n < (1 << OP_W); n++)
            issue(OP_W'(n), '1, '1, '1, 0);
        issue(OP_REMOVE, 12'd100, '0, '0, 0);  // table empties
        issue(OP_GET, 12'd100, '0, '0, 0);

        filling = 1'b1;
        full_hits = 0;
        for (n = 0; n < ITEM_TARGET; n++)
        begin
            if (n % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == 300 || n == 650)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                while (sent != seen)
                    @(negedge clk);
            end
            if (filling && lay_count == DEPTH)
                full_hits++;
            if (full_hits >= 30)
            begin
                filling = 1'b0;
                full_hits = 0;
            end
            if (!filling && lay_count <= 4)
                filling = 1'b1;

            r = $urandom_range(0, 99);
            if (filling)
                pick = r < 55 ? OP_PUT : r < 67 ? OP_RESERVE : r < 77 ? OP_GET :
                       r < 83 ? OP_REMOVE : r < 96 ? OP_READ : OP_W'(OP_READ + 1);
            else
                pick = r < 15 ? OP_PUT : r < 20 ? OP_RESERVE : r < 35 ? OP_GET :
                       r < 80 ? OP_REMOVE : r < 96 ? OP_READ : OP_W'(OP_READ + 1);
            if (pick > OP_READ)
                pick = OP_W'($urandom_range(OP_READ + 1, (1 << OP_W) - 1));
            if (lay_count > 0 && $urandom_range(0, 4) != 0)
                pos_pick = SLOT_W'($urandom_range(0, lay_count - 1));
            else
                pos_pick = SLOT_W'($urandom);
            issue(pick, pick_key((pick == OP_PUT || pick == OP_RESERVE) && filling ? 15 : 80),
                  $urandom, pos_pick, idle_len());
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (sent != seen)
            @(negedge clk);
        repeat (20) @(negedge clk);
        checks_closed <= 1'b1;
        repeat (2) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/sst_pkg.sv
design/sst_ctrl.sv
design/sst_datapath.sv
design/sparse_set_table.sv
sim/sst_result_checker.sv
sim/tb_sparse_set_table.sv
